[rtl/parabolic_mirror_test_and_reflect_core_defines.svh]
// Assertion macros for the parabolic mirror core.
// Included by the top level; empty when SYNTHESIS is defined.
`ifndef PARABOLIC_MIRROR_TEST_AND_REFLECT_CORE_DEFINES_SVH
`define PARABOLIC_MIRROR_TEST_AND_REFLECT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PMTR_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PMTR_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PMTR_ASSERT(label, clk, rst_n, prop, msg)
`define PMTR_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

[rtl/pmtr_pkg.sv]
// Types and constants for the parabolic mirror core.
// No dependencies; used by every other RTL file but the defines header.
`default_nettype none
package pmtr_pkg;
	localparam int POS_FRAC_BITS  = 16;
	localparam int CURV_FRAC_BITS = 24;
	localparam int SCALE_SH       = CURV_FRAC_BITS + POS_FRAC_BITS;
	localparam int NORM_BITS      = 22;
	localparam int KMIN           = SCALE_SH - (NORM_BITS - 1);
	localparam int K_W            = 7;
	localparam int SQ_W           = 2 * NORM_BITS;
	localparam int DEN_W          = SQ_W + 1;
	localparam int NUM_W          = 61;
	localparam int Q_W            = 16;
	localparam int Q_BOUND        = 46340;

	typedef logic signed [31:0] pos_t;
	typedef logic signed [15:0] dir_t;
	typedef logic [30:0]        ha_t;
	typedef logic [Q_W-1:0]     quo_t;

	typedef enum logic [2:0] {
		REG_VERTEX_X      = 3'd0,
		REG_VERTEX_Y      = 3'd1,
		REG_HALF_APERTURE = 3'd2,
		REG_CURVATURE     = 3'd3,
		REG_CONCAVE_UP    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic valid;
		logic is_in;
		logic neg_x;
		logic neg_y;
	} pmtr_ctl_t;

	typedef struct packed {
		logic is_in;
		dir_t x;
		dir_t y;
	} pmtr_res_t;
endpackage
`default_nettype wire

[rtl/pmtr_if.sv]
// Request and result channel interfaces of the parabolic mirror core.
// Depends on pmtr_pkg.
`default_nettype none
interface pmtr_in_if;
	import pmtr_pkg::*;
	logic valid;
	logic ready;
	pos_t point_x;
	pos_t point_y;
	dir_t dir_x;
	dir_t dir_y;
	modport source(output valid, point_x, point_y, dir_x, dir_y, input ready);
	modport sink(input valid, point_x, point_y, dir_x, dir_y, output ready);
endinterface

interface pmtr_out_if;
	import pmtr_pkg::*;
	logic valid;
	logic ready;
	logic inside_res;
	dir_t refl_x;
	dir_t refl_y;
	modport source(output valid, inside_res, refl_x, refl_y, input ready);
	modport sink(input valid, inside_res, refl_x, refl_y, output ready);
endinterface
`default_nettype wire

[rtl/parabolic_mirror_test_and_reflect_core.sv]
// Parabolic mirror point test and ray reflection, top level.
// Depends on pmtr_pkg, pmtr_if, pmtr_front, pmtr_div and the defines header.
//
// Use: requests arrive on items (point, incoming direction); each gives one
// result on results (inside flag, reflected direction). Both channels move a
// request at a rising edge with valid and ready high. Mirror registers are
// written through wr_en / wr_idx / wr_data; the user must write them only while
// the block is idle, which the block does not enforce. An unknown index is ignored.
// From acceptance to result valid a request passes nine front stages
// (offset, squares, curve scaling, normalization, numerators), sixteen
// divider stages at one quotient bit each, and the output register.
// Throughput is one request per cycle while items.ready is high; the divider stages set the depth.
// Reset clears all valid bits and loads the register defaults (vertex at the
// origin, half aperture 1.0, curvature 0.25, opening upward).
// When results stalls, one more result is held in a skid register; after
// that the whole pipeline holds and items.ready drops.
`default_nettype none
`include "parabolic_mirror_test_and_reflect_core_defines.svh"
module parabolic_mirror_test_and_reflect_core (
	input  wire        clk,
	input  wire        arst_n,
	pmtr_in_if.sink    items,
	pmtr_out_if.source results,
	input  wire        wr_en,
	input  wire [2:0]  wr_idx,
	input  wire [31:0] wr_data
);
	import pmtr_pkg::*;

	pos_t vertex_x_q, vertex_y_q, curvature_q;
	ha_t  half_aperture_q;
	logic concave_up_q;

	logic             en;
	pmtr_ctl_t        ctl_f, ctl_d;
	logic [NUM_W-1:0] num_x, num_y;
	logic [DEN_W-1:0] den;
	quo_t             quo_x, quo_y;
	pmtr_res_t        res, out_q, skid_q;
	logic             ov_q, sk_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_x_q      <= '0;
			vertex_y_q      <= '0;
			half_aperture_q <= 31'd65536;
			curvature_q     <= 32'sd4194304;
			concave_up_q    <= 1'b1;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_idx))
				REG_VERTEX_X:      vertex_x_q      <= wr_data;
				REG_VERTEX_Y:      vertex_y_q      <= wr_data;
				REG_HALF_APERTURE: half_aperture_q <= wr_data[30:0];
				REG_CURVATURE:     curvature_q     <= wr_data;
				REG_CONCAVE_UP:    concave_up_q    <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign en          = !sk_v_q;
	assign items.ready = en;

	pmtr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (items.valid),
		.point_x       (items.point_x),
		.point_y       (items.point_y),
		.dir_x         (items.dir_x),
		.dir_y         (items.dir_y),
		.vertex_x      (vertex_x_q),
		.vertex_y      (vertex_y_q),
		.half_aperture (half_aperture_q),
		.curvature     (curvature_q),
		.concave_up    (concave_up_q),
		.ctl           (ctl_f),
		.num_x         (num_x),
		.num_y         (num_y),
		.den           (den)
	);

	pmtr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_f),
		.num_x   (num_x),
		.num_y   (num_y),
		.den     (den),
		.ctl_out (ctl_d),
		.quo_x   (quo_x),
		.quo_y   (quo_y)
	);

	always_comb begin
		res.is_in = ctl_d.is_in;
		if (ctl_d.neg_x)
			res.x = (quo_x > 16'd32768) ? 16'sh8000 : $signed(-quo_x);
		else
			res.x = (quo_x > 16'd32767) ? 16'sh7FFF : $signed(quo_x);
		if (ctl_d.neg_y)
			res.y = (quo_y > 16'd32768) ? 16'sh8000 : $signed(-quo_y);
		else
			res.y = (quo_y > 16'd32767) ? 16'sh7FFF : $signed(quo_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			sk_v_q <= 1'b0;
		end else if (!ov_q || results.ready) begin
			if (sk_v_q) begin
				ov_q   <= 1'b1;
				sk_v_q <= 1'b0;
			end else begin
				ov_q <= ctl_d.valid;
			end
		end else if (ctl_d.valid && !sk_v_q) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ov_q || results.ready)
			out_q <= sk_v_q ? skid_q : res;
		else if (!sk_v_q)
			skid_q <= res;
	end

	assign results.valid      = ov_q;
	assign results.inside_res = out_q.is_in;
	assign results.refl_x     = out_q.x;
	assign results.refl_y     = out_q.y;

	`PMTR_ASSERT(a_skid_needs_out, clk, arst_n, sk_v_q |-> ov_q, "skid full with output empty")
	`PMTR_ASSERT(a_stall_to_skid, clk, arst_n, (ctl_d.valid && !sk_v_q && ov_q && !results.ready) |=> sk_v_q, "result dropped on stall")
	`PMTR_NEVER(a_quo_range, clk, arst_n, ctl_d.valid && (quo_x > 16'(Q_BOUND) || quo_y > 16'(Q_BOUND)), "quotient out of range")
endmodule
`default_nettype wire

[rtl/pmtr_front.sv]
// Front pipeline: offset, curve test, slope scaling and numerators (nine stages).
// Depends on pmtr_pkg.
`default_nettype none
module pmtr_front (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      en,
	input  wire                      in_valid,
	input  pmtr_pkg::pos_t           point_x,
	input  pmtr_pkg::pos_t           point_y,
	input  pmtr_pkg::dir_t           dir_x,
	input  pmtr_pkg::dir_t           dir_y,
	input  pmtr_pkg::pos_t           vertex_x,
	input  pmtr_pkg::pos_t           vertex_y,
	input  pmtr_pkg::ha_t            half_aperture,
	input  pmtr_pkg::pos_t           curvature,
	input  wire                      concave_up,
	output pmtr_pkg::pmtr_ctl_t      ctl,
	output logic [pmtr_pkg::NUM_W-1:0] num_x,
	output logic [pmtr_pkg::NUM_W-1:0] num_y,
	output logic [pmtr_pkg::DEN_W-1:0] den
);
	import pmtr_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	logic signed [32:0] dx;
	logic [32:0]        ndx;
	logic [31:0]        adx;
	logic [31:0]        am;
	logic               cneg;

	logic [31:0] adx_s1;
	logic        dneg_s1;
	pos_t        py_s1, py_s2, py_s3, py_s4, py_s5;
	dir_t        ix_s1, ix_s2, ix_s3, ix_s4, ix_s5, ix_s6;
	dir_t        iy_s1, iy_s2, iy_s3, iy_s4, iy_s5, iy_s6;

	logic [63:0] sq_s2, tm_s2, tm_s3, p0_s3, p1_s3;
	logic        ap_s2, ap_s3, ap_s4, ap_s5;
	logic        tneg_s2, tneg_s3, tneg_s4, tneg_s5;
	logic [K_W-1:0] blen, kk, k_s3;

	logic [95:0] full;
	logic [34:0] m_s4;
	logic [NORM_BITS-1:0] tp_s4, dp_s4;

	logic signed [36:0] csum;
	pos_t               cy_s5;
	logic [SQ_W-1:0]    dd_s5, tt_s5, td_s5;

	logic [SQ_W:0]             s2m;
	logic [DEN_W-1:0]          den_s6, den_s7, den_s8, den_s9;
	logic signed [DEN_W-1:0]   c_s6, s2_s6;
	logic                      in_s6, in_s7, in_s8, in_s9;

	logic signed [60:0] pxc_s7, pys_s7, pxs_s7, pyc_s7;
	logic signed [61:0] nx_s8, ny_s8, nnx, nny;
	logic [NUM_W-1:0]   nx_s9, ny_s9;
	logic               negx_s9, negy_s9;

	assign dx   = 33'(point_x) - 33'(vertex_x);
	assign ndx  = -dx;
	assign adx  = dx[32] ? ndx[31:0] : dx[31:0];
	assign cneg = curvature[31];
	assign am   = cneg ? 32'(-curvature) : 32'(curvature);

	always_comb begin
		blen = '0;
		for (int b = 0; b < 64; b++) begin
			if (tm_s2[b]) blen = K_W'(b + 1);
		end
		kk = (blen > K_W'(KMIN + NORM_BITS)) ? blen - K_W'(NORM_BITS) : K_W'(KMIN);
	end

	assign full = {32'b0, p0_s3} + {p1_s3, 32'b0};
	assign csum = (cneg ? -37'(m_s4) : 37'(m_s4)) + 37'(vertex_y);
	assign s2m  = {td_s5, 1'b0};
	assign nnx  = -nx_s8;
	assign nny  = -ny_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			adx_s1  <= adx;
			dneg_s1 <= dx[32];
			py_s1   <= point_y;
			ix_s1   <= dir_x;
			iy_s1   <= dir_y;

			sq_s2   <= 64'(adx_s1) * 64'(adx_s1);
			tm_s2   <= (64'(am) * 64'(adx_s1)) << 1;
			ap_s2   <= {1'b0, adx_s1} <= {2'b0, half_aperture};
			tneg_s2 <= cneg ^ dneg_s1;
			py_s2   <= py_s1;
			ix_s2   <= ix_s1;
			iy_s2   <= iy_s1;

			p0_s3   <= 64'(sq_s2[31:0]) * 64'(am);
			p1_s3   <= 64'(sq_s2[63:32]) * 64'(am);
			k_s3    <= kk;
			tm_s3   <= tm_s2;
			ap_s3   <= ap_s2;
			tneg_s3 <= tneg_s2;
			py_s3   <= py_s2;
			ix_s3   <= ix_s2;
			iy_s3   <= iy_s2;

			if (full[95:SCALE_SH] > (96 - SCALE_SH)'(35'h4_0000_0000))
				m_s4 <= 35'h4_0000_0000;
			else
				m_s4 <= full[SCALE_SH+34:SCALE_SH];
			tp_s4   <= NORM_BITS'(tm_s3 >> k_s3);
			if (k_s3 > K_W'(SCALE_SH))
				dp_s4 <= '0;
			else
				dp_s4 <= NORM_BITS'(1) << (K_W'(SCALE_SH) - k_s3);
			ap_s4   <= ap_s3;
			tneg_s4 <= tneg_s3;
			py_s4   <= py_s3;
			ix_s4   <= ix_s3;
			iy_s4   <= iy_s3;

			if (csum > 37'sd2147483647)
				cy_s5 <= 32'sh7FFF_FFFF;
			else if (csum < -37'sd2147483648)
				cy_s5 <= 32'sh8000_0000;
			else
				cy_s5 <= csum[31:0];
			dd_s5   <= SQ_W'(dp_s4) * SQ_W'(dp_s4);
			tt_s5   <= SQ_W'(tp_s4) * SQ_W'(tp_s4);
			td_s5   <= SQ_W'(tp_s4) * SQ_W'(dp_s4);
			ap_s5   <= ap_s4;
			tneg_s5 <= tneg_s4;
			py_s5   <= py_s4;
			ix_s5   <= ix_s4;
			iy_s5   <= iy_s4;

			in_s6   <= ap_s5 && (concave_up ? (py_s5 >= cy_s5) : (py_s5 <= cy_s5));
			den_s6  <= DEN_W'(dd_s5) + DEN_W'(tt_s5);
			c_s6    <= $signed(DEN_W'(dd_s5) - DEN_W'(tt_s5));
			s2_s6   <= tneg_s5 ? $signed(-s2m) : $signed(s2m);
			ix_s6   <= ix_s5;
			iy_s6   <= iy_s5;

			pxc_s7  <= ix_s6 * c_s6;
			pys_s7  <= iy_s6 * s2_s6;
			pxs_s7  <= ix_s6 * s2_s6;
			pyc_s7  <= iy_s6 * c_s6;
			den_s7  <= den_s6;
			in_s7   <= in_s6;

			nx_s8   <= 62'(pxc_s7) + 62'(pys_s7);
			ny_s8   <= 62'(pxs_s7) - 62'(pyc_s7);
			den_s8  <= den_s7;
			in_s8   <= in_s7;

			nx_s9   <= nx_s8[61] ? nnx[NUM_W-1:0] : nx_s8[NUM_W-1:0];
			ny_s9   <= ny_s8[61] ? nny[NUM_W-1:0] : ny_s8[NUM_W-1:0];
			negx_s9 <= nx_s8[61];
			negy_s9 <= ny_s8[61];
			den_s9  <= den_s8;
			in_s9   <= in_s8;
		end
	end

	assign ctl.valid  = v_s9;
	assign ctl.is_in  = in_s9;
	assign ctl.neg_x  = negx_s9;
	assign ctl.neg_y  = negy_s9;
	assign num_x      = nx_s9;
	assign num_y      = ny_s9;
	assign den        = den_s9;
endmodule
`default_nettype wire

[rtl/pmtr_div.sv]
// Pipelined restoring divider, one quotient bit per stage, two lanes on one divisor.
// Depends on pmtr_pkg.
`default_nettype none
module pmtr_div (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        en,
	input  pmtr_pkg::pmtr_ctl_t        ctl_in,
	input  wire [pmtr_pkg::NUM_W-1:0]  num_x,
	input  wire [pmtr_pkg::NUM_W-1:0]  num_y,
	input  wire [pmtr_pkg::DEN_W-1:0]  den,
	output pmtr_pkg::pmtr_ctl_t        ctl_out,
	output pmtr_pkg::quo_t             quo_x,
	output pmtr_pkg::quo_t             quo_y
);
	import pmtr_pkg::*;

	pmtr_ctl_t        ctl_s [0:Q_W];
	quo_t             qx_s  [0:Q_W];
	quo_t             qy_s  [0:Q_W];
	logic [NUM_W-1:0] rx_s  [0:Q_W-1];
	logic [NUM_W-1:0] ry_s  [0:Q_W-1];
	logic [DEN_W-1:0] den_s [0:Q_W-1];

	assign ctl_s[0] = ctl_in;
	assign qx_s[0]  = '0;
	assign qy_s[0]  = '0;
	assign rx_s[0]  = num_x;
	assign ry_s[0]  = num_y;
	assign den_s[0] = den;

	for (genvar s = 0; s < Q_W; s++) begin : g_stage
		logic [NUM_W-1:0] dsh;
		logic             gx, gy;

		assign dsh = NUM_W'(den_s[s]) << (Q_W - 1 - s);
		assign gx  = rx_s[s] >= dsh;
		assign gy  = ry_s[s] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[s+1] <= '0;
			end else if (en) begin
				ctl_s[s+1] <= ctl_s[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				qx_s[s+1] <= {qx_s[s][Q_W-2:0], gx};
				qy_s[s+1] <= {qy_s[s][Q_W-2:0], gy};
			end
		end

		if (s < Q_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rx_s[s+1]  <= gx ? rx_s[s] - dsh : rx_s[s];
					ry_s[s+1]  <= gy ? ry_s[s] - dsh : ry_s[s];
					den_s[s+1] <= den_s[s];
				end
			end
		end
	end

	assign ctl_out = ctl_s[Q_W];
	assign quo_x   = qx_s[Q_W];
	assign quo_y   = qy_s[Q_W];
endmodule
`default_nettype wire

[tb/parabolic_mirror_test_and_reflect_core_test.sv]
// Self-checking testbench for the parabolic mirror point test and reflection core.
// Drives requests through pmtr_in_if and checks every result against a local predictor.
// Depends on pmtr_pkg, pmtr_if and the core itself.
module parabolic_mirror_test_and_reflect_core_test;
	import pmtr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		pos_t px;
		pos_t py;
		dir_t ix;
		dir_t iy;
	} ray_t;

	typedef struct {
		logic hit;
		dir_t rx;
		dir_t ry;
	} hit_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [2:0] wr_idx;
	logic [31:0] wr_data;

	pmtr_in_if items_if();
	pmtr_out_if results_if();

	parabolic_mirror_test_and_reflect_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_if),
		.results(results_if),
		.wr_en(wr_en),
		.wr_idx(wr_idx),
		.wr_data(wr_data)
	);

	longint mir_vx, mir_vy, mir_curv, mir_ha;
	bit mir_up;
	ray_t pending_rays[$];
	hit_t expected_hits[$];
	int errors;
	bit calm;
	int send_gap, sink_stall;

	function automatic longint curve_at(longint adx);
		bit [127:0] prod;
		longint am, m, c;
		am = mir_curv < 0 ? -mir_curv : mir_curv;
		prod = 128'(adx) * 128'(adx) * 128'(am);
		prod = prod >> 40;
		m = prod > 128'(64'd1 << 34) ? (64'sd1 <<< 34) : longint'(prod[63:0]);
		c = (mir_curv < 0 ? -m : m) + mir_vy;
		if (c > 64'sd2147483647) c = 64'sd2147483647;
		if (c < -64'sd2147483648) c = -64'sd2147483648;
		return c;
	endfunction

	function automatic hit_t reflect_ray(ray_t r);
		hit_t h;
		longint dx, adx, am, dp, tp, den, c, s2, rx, ry, py;
		bit [127:0] tm, dsc;
		int k;
		dx = longint'(r.px) - mir_vx;
		adx = dx < 0 ? -dx : dx;
		am = mir_curv < 0 ? -mir_curv : mir_curv;
		py = longint'(r.py);
		h.hit = 1'b0;
		if (adx <= mir_ha)
			h.hit = mir_up ? (py >= curve_at(adx)) : (py <= curve_at(adx));
		tm = 128'(am) * 128'(adx) * 2;
		dsc = 128'(1) << 40;
		k = 0;
		while ((dsc >> k) >= (128'(1) << 22) || (tm >> k) >= (128'(1) << 22))
			k++;
		dp = longint'(dsc >> k);
		tp = longint'(tm >> k);
		if ((mir_curv < 0) != (dx < 0)) tp = -tp;
		den = dp * dp + tp * tp;
		c = dp * dp - tp * tp;
		s2 = 2 * tp * dp;
		rx = (longint'(r.ix) * c + longint'(r.iy) * s2) / den;
		ry = (longint'(r.ix) * s2 - longint'(r.iy) * c) / den;
		if (rx > 32767) rx = 32767;
		if (rx < -32768) rx = -32768;
		if (ry > 32767) ry = 32767;
		if (ry < -32768) ry = -32768;
		h.rx = dir_t'(rx);
		h.ry = dir_t'(ry);
		return h;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= data;
		case (idx)
			REG_VERTEX_X: mir_vx = longint'($signed(data));
			REG_VERTEX_Y: mir_vy = longint'($signed(data));
			REG_HALF_APERTURE: mir_ha = longint'(data[30:0]);
			REG_CURVATURE: mir_curv = longint'($signed(data));
			REG_CONCAVE_UP: mir_up = data[0];
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_mirror(logic [31:0] vx, logic [31:0] vy, logic [31:0] ha,
			logic [31:0] cv, logic up);
		write_reg(REG_VERTEX_X, vx);
		write_reg(REG_VERTEX_Y, vy);
		write_reg(REG_HALF_APERTURE, ha);
		write_reg(REG_CURVATURE, cv);
		write_reg(REG_CONCAVE_UP, {31'd0, up});
	endtask

	task automatic drain;
		while (pending_rays.size() != 0 || items_if.valid || expected_hits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_ray(logic [31:0] px, logic [31:0] py, logic [15:0] ix,
			logic [15:0] iy);
		ray_t r;
		r.px = px;
		r.py = py;
		r.ix = ix;
		r.iy = iy;
		pending_rays.push_back(r);
	endtask

	function automatic logic [15:0] rand_dir();
		if ($urandom_range(0, 7) == 0) return 16'($urandom);
		return 16'($urandom_range(0, 32768) - 16384);
	endfunction

	task automatic push_random_ray();
		longint dx, cy;
		logic [31:0] px, py;
		case ($urandom_range(0, 9))
			0, 1: begin
				px = $urandom;
				py = $urandom;
			end
			2: begin
				px = 32'(mir_vx);
				py = $urandom;
			end
			default: begin
				dx = longint'($urandom_range(0, 32'(mir_ha) > 0 ? 32'(mir_ha) : 0));
				if ($urandom_range(0, 1)) dx = -dx;
				if ($urandom_range(0, 5) == 0) dx = dx + 1;
				px = 32'(mir_vx + dx);
				dx = longint'($signed(px)) - mir_vx;
				cy = curve_at(dx < 0 ? -dx : dx);
				py = 32'(cy + longint'($urandom_range(0, 8)) - 4);
				if ($urandom_range(0, 3) == 0) py = 32'(cy + longint'($signed($urandom)) / 64);
			end
		endcase
		push_ray(px, py, rand_dir(), rand_dir());
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_if.valid <= 1'b0;
			send_gap <= 0;
		end else if (!items_if.valid || items_if.ready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				items_if.valid <= 1'b0;
			end else if (pending_rays.size() != 0) begin
				ray_t r;
				r = pending_rays.pop_front();
				items_if.valid <= 1'b1;
				items_if.point_x <= r.px;
				items_if.point_y <= r.py;
				items_if.dir_x <= r.ix;
				items_if.dir_y <= r.iy;
				if (!calm && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 4);
			end else begin
				items_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
			sink_stall <= 0;
		end else begin
			if (items_if.valid && items_if.ready) begin
				ray_t r;
				r.px = items_if.point_x;
				r.py = items_if.point_y;
				r.ix = items_if.dir_x;
				r.iy = items_if.dir_y;
				expected_hits.push_back(reflect_ray(r));
			end
			if (results_if.valid && results_if.ready) begin
				if (expected_hits.size() == 0) begin
					$display("%t unexpected result: inside=%0b x=%0d y=%0d", $realtime,
						results_if.inside_res, results_if.refl_x, results_if.refl_y);
					errors++;
				end else begin
					hit_t e;
					e = expected_hits.pop_front();
					if (results_if.inside_res !== e.hit) begin
						$display("%t inside: expected %0b, actual %0b", $realtime, e.hit,
							results_if.inside_res);
						errors++;
					end
					if (results_if.refl_x !== e.rx) begin
						$display("%t refl_x: expected %0d, actual %0d", $realtime, e.rx,
							results_if.refl_x);
						errors++;
					end
					if (results_if.refl_y !== e.ry) begin
						$display("%t refl_y: expected %0d, actual %0d", $realtime, e.ry,
							results_if.refl_y);
						errors++;
					end
				end
			end
			if (sink_stall > 0) begin
				sink_stall <= sink_stall - 1;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0) sink_stall <= $urandom_range(1, 4);
			end
		end
	end

	initial begin
		errors = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_idx = '0;
		wr_data = '0;
		items_if.valid = 1'b0;
		items_if.point_x = '0;
		items_if.point_y = '0;
		items_if.dir_x = '0;
		items_if.dir_y = '0;
		results_if.ready = 1'b0;
		mir_vx = 0;
		mir_vy = 0;
		mir_ha = 65536;
		mir_curv = 4194304;
		mir_up = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset mirror: vertex, edges of aperture, on the curve, extreme inputs
		push_ray(32'd0, 32'd0, 16'sd16384, 16'sd16384);
		push_ray(32'd0, 32'd5, 16'h7FFF, 16'h8000);
		push_ray(32'd65536, 32'd16384, 16'sd16384, -16'sd16384);
		push_ray(32'd65536, 32'd16383, -16'sd16384, 16'sd0);
		push_ray(32'd65537, 32'h7FFFFFFF, 16'sd0, 16'sd16384);
		push_ray(-32'sd65536, 32'd16384, 16'h8000, 16'h7FFF);
		push_ray(32'h80000000, 32'h80000000, 16'hFFFF, 16'h0001);
		push_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF, 16'h7FFF);
		push_ray(32'd32768, 32'd4096, 16'sd11585, -16'sd11585);
		drain();

		write_reg(REG_UNUSED, 32'hFFFFFFFF);
		set_mirror(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
		push_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 16'sd16384, 16'sd16384);
		push_ray(32'h80000000, 32'h80000000, 16'sd16384, -16'sd16384);
		push_ray(32'h00000000, 32'h7FFFFFFF, 16'h7FFF, 16'h8000);
		push_ray(32'h80000001, 32'h00000000, -16'sd16384, 16'sd1);
		drain();

		set_mirror(32'h7FFFFFFF, 32'h80000000, 32'd0, 32'h80000000, 1'b1);
		push_ray(32'h7FFFFFFF, 32'h80000000, 16'sd16384, 16'sd16384);
		push_ray(32'h7FFFFFFF, 32'h80000001, 16'h8000, 16'h8000);
		push_ray(32'h80000000, 32'h00000000, 16'sd100, -16'sd16384);
		push_ray(32'h7FFFFFFE, 32'h80000000, 16'sd16384, 16'sd0);
		drain();

		set_mirror(32'd0, 32'd0, 32'd1 << 20, 32'd0, 1'b0);
		push_ray(32'd1000, 32'd0, 16'sd12000, 16'sd3000);
		push_ray(32'd1000, 32'd1, 16'sd12000, 16'sd3000);
		push_ray(-32'sd1000, -32'sd1, 16'h8000, 16'h7FFF);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 11) calm = 1'b1;
			case (ph % 4)
				0: set_mirror($urandom, $urandom, $urandom_range(0, 32'h7FFFFFFF), $urandom,
					$urandom_range(0, 1));
				1: set_mirror(32'($signed($urandom) / 256), 32'($signed($urandom) / 256),
					$urandom_range(0, 1 << 22), 32'($signed($urandom) / 32),
					$urandom_range(0, 1));
				2: set_mirror($urandom, $urandom, $urandom_range(0, 1 << 18),
					32'($signed($urandom) / 4096), $urandom_range(0, 1));
				default: set_mirror($urandom, $urandom, $urandom_range(1 << 16, 1 << 24),
					$urandom_range(0, 1 << 26), $urandom_range(0, 1));
			endcase
			for (int n = 0; n < 100; n++) push_random_ray();
			drain();
		end

		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
